// ===== hdl/ffa_pkg.sv =====
// Shared constants and types for the first-fit block allocator.
// No dependencies; imported by ffa_ram users and the top level.
`default_nettype none

package ffa_pkg;

    // Cell store size and derived widths
    localparam int MEM_CELLS = 128;
    localparam int ADDR_W    = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
    localparam int CNT_W     = $clog2(MEM_CELLS + 1);
    localparam int OWNER_W   = 16;

    // Reset values
    localparam logic [7:0]         CELLS_RESET  = 8'd128;
    localparam logic [OWNER_W-1:0] HANDLE_FIRST = 16'd1;
    localparam logic [31:0]        HANDLE_MAX   = 32'd65535;

    // Command codes
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_ERASE  = 2'd1;
    localparam logic [1:0] CMD_DEFRAG = 2'd2;

    // Status codes
    localparam logic [2:0] STAT_ALLOC_OK   = 3'd0;
    localparam logic [2:0] STAT_ALLOC_FAIL = 3'd1;
    localparam logic [2:0] STAT_ERASED     = 3'd2;
    localparam logic [2:0] STAT_BAD_ERASE  = 3'd3;
    localparam logic [2:0] STAT_DEFRAG     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_FILL,
        S_ERASE_SCAN,
        S_DEFRAG_SCAN,
        S_DEFRAG_CLEAR
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/ffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/first_fit_block_allocator.sv =====
// First-fit contiguous cell allocator with compaction: top level.
// Depends on ffa_pkg and ffa_ram.
`default_nettype none

// Channel     | Signals                        | Handshake
// ------------+--------------------------------+------------------------------------
// request     | command, operand               | taken when start && !busy
// result      | status, handle                 | done high for one cycle, no stall
// config      | cfg_data (cells_in_use)        | written when cfg_valid && cfg_ready
//
// Operation: allocate scans for a free run, then writes each claimed cell;
// erase scans once; defragment does a read pass, then a zero-fill of the
// tail. Each scan covers the managed cell count. The owner RAM has one
// read and one write port, so scans go one cell a cycle.
// Requests that fail their argument checks answer in the next cycle.
// Reset: all cells read as free through per-entry valid bits cleared at once,
// so no clearing pass is needed; the handle counter restarts at 1.
// The result receiver cannot stall; a new request may arrive during done.

module first_fit_block_allocator
    import ffa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] operand,
    // result
    output logic                    done,
    output logic [2:0]              status,
    output logic [15:0]             handle,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);

    state_t state_reg, state_next;

    logic [7:0]         cells_in_use_reg;
    logic [OWNER_W-1:0] next_handle_reg, next_handle_next;
    logic [31:0]        operand_reg, operand_next;

    // scan read pipeline
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               rd_pend_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;
    logic               vld_q_reg;

    // per-operation bookkeeping
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [ADDR_W-1:0]  start_idx_reg, start_idx_next;
    logic [ADDR_W-1:0]  end_idx_reg, end_idx_next;
    logic [ADDR_W-1:0]  fill_idx_reg, fill_idx_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   w_reg, w_next;

    // result register
    logic               done_reg, done_next;
    logic [2:0]         status_reg, status_next;
    logic [15:0]        handle_reg, handle_next;

    // valid bit per cell: an unwritten cell reads as free
    logic [MEM_CELLS-1:0] vld_reg;

    // RAM ports
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [OWNER_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [OWNER_W-1:0] rd_data;

    logic [CNT_W-1:0]   n_cells;
    logic [OWNER_W-1:0] owner;
    logic               last;
    logic [CNT_W-1:0]   run_inc;
    logic [CNT_W-1:0]   size;
    logic [31:0]        op_u;
    logic               alloc_bad;
    logic               erase_bad;

    ffa_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (MEM_CELLS)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Managed count: the register capped at the store size
    assign n_cells = (32'(cells_in_use_reg) > MEM_CELLS) ? CNT_W'(MEM_CELLS)
                                                          : CNT_W'(cells_in_use_reg);

    assign owner   = vld_q_reg ? rd_data : '0;
    assign last    = rd_pend_reg && (CNT_W'(rd_idx_reg) + 1'b1 == n_cells);
    assign run_inc = run_reg + 1'b1;
    assign size    = CNT_W'(operand_reg);
    assign op_u    = operand;

    assign alloc_bad = op_u[31] || (op_u == 32'd0) || (op_u > 32'(n_cells))
                       || (next_handle_reg == '0);
    assign erase_bad = op_u[31] || (op_u == 32'd0) || (op_u > HANDLE_MAX)
                       || ((next_handle_reg != '0) && (op_u >= 32'(next_handle_reg)))
                       || (n_cells == '0);

    // Issue one sequential read a cycle while scanning
    assign rd_addr = rd_cnt_reg[ADDR_W-1:0];
    assign rd_en   = ((state_reg == S_ALLOC_SCAN) || (state_reg == S_ERASE_SCAN)
                      || (state_reg == S_DEFRAG_SCAN)) && (rd_cnt_reg < n_cells);

    always_comb
    begin
        state_next       = state_reg;
        next_handle_next = next_handle_reg;
        operand_next     = operand_reg;
        rd_cnt_next      = rd_cnt_reg;
        run_next         = run_reg;
        start_idx_next   = start_idx_reg;
        end_idx_next     = end_idx_reg;
        fill_idx_next    = fill_idx_reg;
        found_next       = found_reg;
        w_next           = w_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        handle_next      = handle_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        if (rd_en)
        begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    operand_next = op_u;
                    rd_cnt_next  = '0;
                    run_next     = '0;
                    found_next   = 1'b0;
                    w_next       = '0;
                    handle_next  = '0;
                    case (command)
                        CMD_ALLOC:
                        begin
                            if (alloc_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_ALLOC_FAIL;
                            end
                            else
                            begin
                                state_next = S_ALLOC_SCAN;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (erase_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_BAD_ERASE;
                            end
                            else
                            begin
                                state_next = S_ERASE_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused command code acts as defragment
                            if (n_cells == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_DEFRAG;
                            end
                            else
                            begin
                                state_next = S_DEFRAG_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_ALLOC_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (owner == '0)
                    begin
                        run_next = run_inc;
                        if (run_reg == '0)
                        begin
                            start_idx_next = rd_idx_reg;
                        end
                        if (run_inc == size)
                        begin
                            // run long enough: claim it
                            end_idx_next  = rd_idx_reg;
                            fill_idx_next = (run_reg == '0) ? rd_idx_reg : start_idx_reg;
                            state_next    = S_ALLOC_FILL;
                        end
                        else if (last)
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_ALLOC_FAIL;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                        if (last)
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_ALLOC_FAIL;
                            state_next  = S_IDLE;
                        end
                    end
                end
            end

            S_ALLOC_FILL:
            begin
                wr_en         = 1'b1;
                wr_addr       = fill_idx_reg;
                wr_data       = next_handle_reg;
                fill_idx_next = fill_idx_reg + 1'b1;
                if (fill_idx_reg == end_idx_reg)
                begin
                    done_next        = 1'b1;
                    status_next      = STAT_ALLOC_OK;
                    handle_next      = next_handle_reg;
                    next_handle_next = next_handle_reg + 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_ERASE_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (owner == operand_reg[OWNER_W-1:0])
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = rd_idx_reg;
                        found_next = 1'b1;
                    end
                    if (last)
                    begin
                        done_next   = 1'b1;
                        status_next = (found_reg || (owner == operand_reg[OWNER_W-1:0]))
                                      ? STAT_ERASED : STAT_BAD_ERASE;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_DEFRAG_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    // write pointer never passes the read pointer
                    if (owner != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = w_reg[ADDR_W-1:0];
                        wr_data = owner;
                        w_next  = w_reg + 1'b1;
                    end
                    if (last)
                    begin
                        state_next = S_DEFRAG_CLEAR;
                    end
                end
            end

            S_DEFRAG_CLEAR:
            begin
                if (w_reg == n_cells)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_DEFRAG;
                    state_next  = S_IDLE;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = w_reg[ADDR_W-1:0];
                    w_next  = w_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cells_in_use_reg <= CELLS_RESET;
            next_handle_reg  <= HANDLE_FIRST;
            rd_pend_reg      <= 1'b0;
            done_reg         <= 1'b0;
            vld_reg          <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            next_handle_reg <= next_handle_next;
            rd_pend_reg     <= rd_en;
            done_reg        <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cells_in_use_reg <= cfg_data;
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload and bookkeeping registers: no reset needed
    always_ff @(posedge clk)
    begin
        operand_reg   <= operand_next;
        rd_cnt_reg    <= rd_cnt_next;
        rd_idx_reg    <= rd_addr;
        vld_q_reg     <= vld_reg[rd_addr];
        run_reg       <= run_next;
        start_idx_reg <= start_idx_next;
        end_idx_reg   <= end_idx_next;
        fill_idx_reg  <= fill_idx_next;
        found_reg     <= found_next;
        w_reg         <= w_next;
        status_reg    <= status_next;
        handle_reg    <= handle_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign status    = status_reg;
    assign handle    = handle_reg;

`ifndef SYNTH
    // Results appear only after a request or ongoing work
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result strobe without a request");

    // The owner store is written only while a request is in progress
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy)
        else $error("owner RAM write while idle");

    // A successful allocation always carries a nonzero handle, others zero
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_ALLOC_OK)) |-> (handle != '0))
        else $error("allocation returned handle zero");

    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_ALLOC_OK)) |-> (handle == '0))
        else $error("nonzero handle on a non-allocation result");

    // Claim fill never runs past the end of the found run
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_FILL) |-> (fill_idx_reg <= end_idx_reg))
        else $error("fill index beyond claimed run");
`endif

endmodule

`default_nettype wire
